// ===== rtl/cpf_pkg.sv =====
// Package: shared types, codes and sizes for the command packet framer.
`timescale 1ns / 1ps
`default_nettype none

package cpf_pkg;

   // Item codes carried on the opcode field.
   typedef enum logic {
      OP_HEADER = 1'b0,
      OP_DATA   = 1'b1
   } opcode_type;

   // Register indexes on the csr port.
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_START_BYTE = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_END_BYTE   = 1'b1;

   localparam logic [7:0] START_BYTE_RESET = 8'h01;
   localparam logic [7:0] END_BYTE_RESET   = 8'h03;

   // Chunk queue depth, a power of two, at least 4.
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      logic       last;
   } chunk_type;

   // Up to two chunks produced by one accepted word.
   typedef struct packed {
      logic [1:0] n;
      chunk_type  c0;
      chunk_type  c1;
   } push_type;

endpackage

`default_nettype wire

// ===== rtl/cpf_frame.sv =====
// Framing state: running sum, byte count, pending data and chunk building.
`timescale 1ns / 1ps
`default_nettype none

module cpf_frame (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  accept,
   input  wire logic                                  opcode,
   input  wire logic [7:0]                            packet_kind,
   input  wire logic [7:0]                            command,
   input  wire logic [15:0]                           data_length,
   input  wire logic [7:0]                            data_byte,
   input  wire logic                                  csr_write,
   input  wire logic [cpf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [7:0]                            csr_wdata,
   output cpf_pkg::push_type                          push
);
   import cpf_pkg::*;

   logic [7:0]  start_ff, start_in;
   logic [7:0]  end_ff, end_in;
   logic [15:0] left_ff, left_in;
   logic [7:0]  sum_ff, sum_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        open_ff, open_in;
   logic [7:0]  pend_ff [3];
   logic [7:0]  pend_in [3];

   logic [15:0] hdr_len;
   logic        pre_valid;
   chunk_type   pre;
   logic        done;
   logic [1:0]  fill;
   logic [7:0]  crc;
   chunk_type   fin_a, fin_b;
   logic [1:0]  fin_n;

   // Config registers
   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      if (csr_write) begin
         case (csr_index)
            REG_START_BYTE: start_in = csr_wdata;
            REG_END_BYTE:   end_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // Next state and the chunk that precedes any closing chunk
   always_comb begin
      left_in   = left_ff;
      sum_in    = sum_ff;
      cnt_in    = cnt_ff;
      open_in   = open_ff;
      pre_valid = 1'b0;
      pre       = '0;
      done      = 1'b0;
      hdr_len   = data_length + 16'd1;
      for (int i = 0; i < 3; i++) begin
         pend_in[i] = pend_ff[i];
      end
      if (accept) begin
         if (opcode == OP_HEADER) begin
            pre_valid = 1'b1;
            pre       = {start_ff | packet_kind, hdr_len[15:8], hdr_len[7:0], command, 1'b0};
            sum_in    = hdr_len[15:8] + hdr_len[7:0] + command;
            left_in   = data_length;
            cnt_in    = 2'd0;
            open_in   = 1'b1;
            done      = (data_length == 16'd0);
         end else if (open_ff) begin
            sum_in  = sum_ff + data_byte;
            left_in = left_ff - 16'd1;
            if (cnt_ff == 2'd3) begin
               pre_valid = 1'b1;
               pre       = {pend_ff[0], pend_ff[1], pend_ff[2], data_byte, 1'b0};
               cnt_in    = 2'd0;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  if (cnt_ff == 2'(i)) begin
                     pend_in[i] = data_byte;
                  end
               end
               cnt_in = cnt_ff + 2'd1;
            end
            done = (left_ff == 16'd1);
         end
      end
      fill = cnt_in;
      if (done) begin
         cnt_in  = 2'd0;
         open_in = 1'b0;
      end
   end

   // Closing chunk(s) from the fill level after this word
   always_comb begin
      crc   = 8'd0 - sum_in;
      fin_b = {end_ff, 8'd0, 8'd0, 8'd0, 1'b1};
      fin_n = 2'd1;
      case (fill)
         2'd0: fin_a = {crc, end_ff, 8'd0, 8'd0, 1'b1};
         2'd1: fin_a = {pend_in[0], crc, end_ff, 8'd0, 1'b1};
         2'd2: fin_a = {pend_in[0], pend_in[1], crc, end_ff, 1'b1};
         default: begin
            fin_a = {pend_in[0], pend_in[1], pend_in[2], crc, 1'b0};
            fin_n = 2'd2;
         end
      endcase
   end

   always_comb begin
      push.n  = {1'b0, pre_valid} + (done ? fin_n : 2'd0);
      push.c0 = pre_valid ? pre : fin_a;
      push.c1 = pre_valid ? fin_a : fin_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_BYTE_RESET;
         end_ff   <= END_BYTE_RESET;
         left_ff  <= '0;
         sum_ff   <= '0;
         cnt_ff   <= '0;
         open_ff  <= 1'b0;
      end else begin
         start_ff <= start_in;
         end_ff   <= end_in;
         left_ff  <= left_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         open_ff  <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         pend_ff[i] <= pend_in[i];
      end
   end

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !open_ff |-> cnt_ff == 2'd0)
      else $error("pending bytes held with no open packet");

   a_empty_closes: assert property (@(posedge clock) disable iff (reset)
      accept && opcode == OP_HEADER && data_length == 16'd0 |=> !open_ff)
      else $error("empty packet left open");

   a_two_ends: assert property (@(posedge clock) disable iff (reset)
      push.n == 2'd2 |-> push.c1.last && !push.c0.last)
      else $error("two chunks without packet end on the second");

endmodule

`default_nettype wire

// ===== rtl/cpf_queue.sv =====
// Chunk queue: takes up to two chunks per cycle, hands out one per cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module cpf_queue #(
   parameter int DEPTH = cpf_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cpf_pkg::push_type push,
   output logic                   full,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output cpf_pkg::chunk_type     rsp_chunk
);
   import cpf_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   chunk_type          q_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ff, wr_in;
   logic [PTR_W-1:0]   rd_ff, rd_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   wr_next;
   logic               pop;

   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_chunk = q_ff[rd_ff];
   // Room for a full two-chunk word is required before accepting.
   assign full      = (count_ff > CNT_W'(DEPTH - 2));
   assign wr_next   = wr_ff + PTR_W'(1);

   always_comb begin
      wr_in    = wr_ff + PTR_W'(push.n);
      rd_in    = rd_ff + PTR_W'(pop);
      count_in = count_ff + CNT_W'(push.n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.n != 2'd0) begin
         q_ff[wr_ff] <= push.c0;
      end
      if (push.n == 2'd2) begin
         q_ff[wr_next] <= push.c1;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) + int'(push.n) <= DEPTH)
      else $error("chunk queue overflow");

   a_push_bound: assert property (@(posedge clock) disable iff (reset)
      push.n != 2'd3)
      else $error("more than two chunks from one word");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      !reset |=> count_ff == $past(count_ff) + CNT_W'($past(push.n)) - CNT_W'($past(pop)))
      else $error("queue count out of step with pushes and pops");

endmodule

`default_nettype wire

// ===== rtl/command_packet_framer.sv =====
// Top level: command packet framer, header and data words in, four-byte chunks out.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  opcode, packet_kind, command,
//                                              data_length, data_byte
//   rsp      out        rsp_valid / rsp_stall  chunk_byte0..3, packet_end
//   csr      in         csr_write              csr_index, csr_wdata
//
// One req word per cycle while req_stall is low; its chunks land in the queue at
// the next edge and go out on rsp one chunk per cycle while rsp_stall is low.
// A word yields zero, one or two chunks; the two-chunk cases (packet close
// with two or three bytes pending, empty packet) set the long-term rate.
// req_stall is high while the queue has room for fewer than two chunks.
// Synchronous reset clears the packet state and queue; start byte 0x01,
// end byte 0x03.
`timescale 1ns / 1ps
`default_nettype none

module command_packet_framer #(
   parameter int QUEUE_DEPTH = cpf_pkg::QUEUE_DEPTH
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic                                  req_opcode,
   input  wire logic [7:0]                            req_packet_kind,
   input  wire logic [7:0]                            req_command,
   input  wire logic [15:0]                           req_data_length,
   input  wire logic [7:0]                            req_data_byte,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [7:0]                                 rsp_chunk_byte0,
   output logic [7:0]                                 rsp_chunk_byte1,
   output logic [7:0]                                 rsp_chunk_byte2,
   output logic [7:0]                                 rsp_chunk_byte3,
   output logic                                       rsp_packet_end,
   input  wire logic                                  csr_write,
   input  wire logic [cpf_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [7:0]                            csr_wdata
);
   import cpf_pkg::*;

   logic      req_accept;
   push_type  push;
   chunk_type chunk;
   logic      full;

   assign req_stall  = full;
   assign req_accept = req_valid && !req_stall;

   cpf_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .opcode      (req_opcode),
      .packet_kind (req_packet_kind),
      .command     (req_command),
      .data_length (req_data_length),
      .data_byte   (req_data_byte),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .push        (push)
   );

   cpf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_chunk (chunk)
   );

   assign rsp_chunk_byte0 = chunk.b0;
   assign rsp_chunk_byte1 = chunk.b1;
   assign rsp_chunk_byte2 = chunk.b2;
   assign rsp_chunk_byte3 = chunk.b3;
   assign rsp_packet_end  = chunk.last;

endmodule

`default_nettype wire

// ===== tb/cpf_chunk_checker.sv =====
// Chunk checker: predicts the framed chunks from accepted words and compares them on rsp.
`timescale 1ns / 1ps

module cpf_chunk_checker
   import cpf_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic                       req_opcode,
   input  logic [7:0]                 req_packet_kind,
   input  logic [7:0]                 req_command,
   input  logic [15:0]                req_data_length,
   input  logic [7:0]                 req_data_byte,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [7:0]                 rsp_chunk_byte0,
   input  logic [7:0]                 rsp_chunk_byte1,
   input  logic [7:0]                 rsp_chunk_byte2,
   input  logic [7:0]                 rsp_chunk_byte3,
   input  logic                       rsp_packet_end,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [7:0]                 csr_wdata,
   output int                         mismatches,
   output int                         outstanding
);

   logic [7:0]  soh_code;
   logic [7:0]  etx_code;
   logic [15:0] bytes_to_go;
   logic [7:0]  byte_sum;
   logic [7:0]  held [3];
   int          held_count;
   logic        frame_open;
   chunk_type   expected_chunks [$];

   function automatic void queue_chunk(input logic [7:0] b0, input logic [7:0] b1,
                                       input logic [7:0] b2, input logic [7:0] b3,
                                       input logic last);
      chunk_type c;
      c.b0 = b0;
      c.b1 = b1;
      c.b2 = b2;
      c.b3 = b3;
      c.last = last;
      expected_chunks.push_back(c);
   endfunction

   // Tail of the packet: leftover bytes, checksum, end code.
   task automatic close_frame();
      logic [7:0] csum;
      csum = 8'd0 - byte_sum;
      case (held_count)
         0: queue_chunk(csum, etx_code, 8'd0, 8'd0, 1'b1);
         1: queue_chunk(held[0], csum, etx_code, 8'd0, 1'b1);
         2: queue_chunk(held[0], held[1], csum, etx_code, 1'b1);
         default: begin
            queue_chunk(held[0], held[1], held[2], csum, 1'b0);
            queue_chunk(etx_code, 8'd0, 8'd0, 8'd0, 1'b1);
         end
      endcase
      held_count = 0;
      frame_open = 1'b0;
   endtask

   task automatic frame_word(input opcode_type op, input logic [7:0] kind,
                             input logic [7:0] cmd, input logic [15:0] dlen,
                             input logic [7:0] dbyte);
      logic [15:0] len_field;
      if (op == OP_HEADER) begin
         // length on the link is data count plus one, 16-bit wrap
         len_field = dlen + 16'd1;
         queue_chunk(soh_code | kind, len_field[15:8], len_field[7:0], cmd, 1'b0);
         byte_sum = len_field[15:8] + len_field[7:0] + cmd;
         bytes_to_go = dlen;
         held_count = 0;
         frame_open = 1'b1;
         if (bytes_to_go == 16'd0) close_frame();
      end else if (frame_open) begin
         byte_sum = byte_sum + dbyte;
         bytes_to_go = bytes_to_go - 16'd1;
         if (held_count == 3) begin
            queue_chunk(held[0], held[1], held[2], dbyte, 1'b0);
            held_count = 0;
         end else begin
            held[held_count] = dbyte;
            held_count++;
         end
         if (bytes_to_go == 16'd0) close_frame();
      end
   endtask

   task automatic compare_chunk();
      chunk_type exp_c;
      if (expected_chunks.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected chunk %h %h %h %h end=%b", $realtime,
                     rsp_chunk_byte0, rsp_chunk_byte1, rsp_chunk_byte2,
                     rsp_chunk_byte3, rsp_packet_end);
      end else begin
         exp_c = expected_chunks.pop_front();
         if (rsp_chunk_byte0 !== exp_c.b0 || rsp_chunk_byte1 !== exp_c.b1 ||
             rsp_chunk_byte2 !== exp_c.b2 || rsp_chunk_byte3 !== exp_c.b3 ||
             rsp_packet_end !== exp_c.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: chunk expected %h %h %h %h end=%b, got %h %h %h %h end=%b",
                        $realtime, exp_c.b0, exp_c.b1, exp_c.b2, exp_c.b3, exp_c.last,
                        rsp_chunk_byte0, rsp_chunk_byte1, rsp_chunk_byte2,
                        rsp_chunk_byte3, rsp_packet_end);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         soh_code = START_BYTE_RESET;
         etx_code = END_BYTE_RESET;
         bytes_to_go = 16'd0;
         byte_sum = 8'd0;
         held_count = 0;
         frame_open = 1'b0;
         mismatches = 0;
         expected_chunks.delete();
      end else begin
         // results of this edge's word cannot show up before the next edge
         if (rsp_valid && !rsp_stall) compare_chunk();
         // a word at this edge still sees the codes from before the write
         if (req_valid && !req_stall)
            frame_word(opcode_type'(req_opcode), req_packet_kind, req_command,
                       req_data_length, req_data_byte);
         if (csr_write) begin
            case (csr_index)
               REG_START_BYTE: soh_code = csr_wdata;
               REG_END_BYTE:   etx_code = csr_wdata;
               default: ;
            endcase
         end
      end
      outstanding = expected_chunks.size();
   end

endmodule

// ===== tb/tb_command_packet_framer.sv =====
// Testbench top: drives header and data words and config writes, gives the verdict.
`timescale 1ns / 1ps

module tb_command_packet_framer;
   import cpf_pkg::*;

   localparam int WORDS_PER_PHASE = 390;
   localparam int BACKLOG_CYCLES  = 300;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid;
   logic                       req_stall;
   logic                       req_opcode;
   logic [7:0]                 req_packet_kind;
   logic [7:0]                 req_command;
   logic [15:0]                req_data_length;
   logic [7:0]                 req_data_byte;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [7:0]                 rsp_chunk_byte0;
   logic [7:0]                 rsp_chunk_byte1;
   logic [7:0]                 rsp_chunk_byte2;
   logic [7:0]                 rsp_chunk_byte3;
   logic                       rsp_packet_end;
   logic                       csr_write;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [7:0]                 csr_wdata;

   int mismatches;
   int outstanding;
   int words_sent = 0;
   bit calm_req = 1'b0;
   int backlog_at [2] = '{400, 1200};

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   command_packet_framer u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_packet_kind (req_packet_kind),
      .req_command     (req_command),
      .req_data_length (req_data_length),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_chunk_byte0 (rsp_chunk_byte0),
      .rsp_chunk_byte1 (rsp_chunk_byte1),
      .rsp_chunk_byte2 (rsp_chunk_byte2),
      .rsp_chunk_byte3 (rsp_chunk_byte3),
      .rsp_packet_end  (rsp_packet_end),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   cpf_chunk_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_packet_kind (req_packet_kind),
      .req_command     (req_command),
      .req_data_length (req_data_length),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_chunk_byte0 (rsp_chunk_byte0),
      .rsp_chunk_byte1 (rsp_chunk_byte1),
      .rsp_chunk_byte2 (rsp_chunk_byte2),
      .rsp_chunk_byte3 (rsp_chunk_byte3),
      .rsp_packet_end  (rsp_packet_end),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   // mostly back to back, some short gaps, a few long ones
   function automatic int idle_span(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance with
   // valid still high, so a following word can go out back to back.
   task automatic send_word(input opcode_type op, input logic [7:0] kind,
                            input logic [7:0] cmd, input logic [15:0] dlen,
                            input logic [7:0] dbyte);
      int gap;
      gap = idle_span(calm_req);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_packet_kind <= kind;
      req_command <= cmd;
      req_data_length <= dlen;
      req_data_byte <= dbyte;
      do @(posedge clock); while (req_stall);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_header(input logic [7:0] kind, input logic [7:0] cmd,
                              input logic [15:0] dlen);
      send_word(OP_HEADER, kind, cmd, dlen, 8'($urandom_range(0, 255)));
   endtask

   task automatic send_data(input logic [7:0] dbyte);
      send_word(OP_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                16'($urandom_range(0, 65535)), dbyte);
   endtask

   // Whole packets with random content; with noise on, some packets are cut
   // short (next header abandons them) and stray data words go out.
   task automatic random_packet(input bit noisy);
      int r;
      int len;
      int cut;
      r = $urandom_range(0, 99);
      calm_req = ($urandom_range(0, 7) == 0);
      if (noisy && r < 4) begin
         send_data(8'($urandom_range(0, 255)));
      end else begin
         if (!noisy) len = $urandom_range(0, 12);
         else if (r < 12) len = 0;
         else if (r < 85) len = $urandom_range(1, 12);
         else if (r < 95) len = $urandom_range(13, 40);
         else len = $urandom_range(41, 65534);
         cut = len;
         if (len > 40 || (noisy && len > 0 && $urandom_range(0, 9) == 0))
            cut = $urandom_range(0, (len - 1 < 40) ? len - 1 : 40);
         send_header(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(len));
         repeat (cut) send_data(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [7:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // word side: reset, directed packets, then random phases with new codes
   initial begin : stimulus
      int phase;
      int phase_end;
      req_valid = 1'b0;
      req_opcode = OP_HEADER;
      req_packet_kind = 8'd0;
      req_command = 8'd0;
      req_data_length = 16'd0;
      req_data_byte = 8'd0;
      csr_write = 1'b0;
      csr_index = REG_START_BYTE;
      csr_wdata = 8'd0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // data with no open packet is dropped
      send_data(8'hA5);
      // empty payload
      send_header(8'h00, 8'h00, 16'd0);
      send_header(8'hFF, 8'hFF, 16'd1);
      send_data(8'hFF);
      send_header(8'h80, 8'h01, 16'd2);
      send_data(8'h00);
      send_data(8'h80);
      // three bytes left: checksum in slot 3, end code in an extra chunk
      send_header(8'h7F, 8'hFE, 16'd3);
      send_data(8'h01);
      send_data(8'hFE);
      send_data(8'h7F);
      // longest length whose length field does not wrap, abandoned by the next header
      send_header(8'h5A, 8'hA5, 16'd65534);
      send_data(8'h11);
      send_data(8'h22);
      send_data(8'h33);
      send_header(8'h3C, 8'hC3, 16'd0);
      send_header(8'h02, 8'h40, 16'd7);
      send_data(8'hDE);
      send_data(8'hAD);
      send_data(8'hBE);
      send_data(8'hEF);
      send_data(8'h55);
      send_data(8'hAA);
      send_data(8'hFF);

      for (phase = 0; phase < 5; phase++) begin
         if (phase > 0) begin
            req_valid <= 1'b0;
            wait (outstanding == 0);
            repeat (4) @(negedge clock);
            case (phase)
               1: begin
                  write_reg(REG_START_BYTE, 8'h00);
                  write_reg(REG_END_BYTE, 8'h00);
               end
               2: begin
                  write_reg(REG_START_BYTE, 8'hFF);
                  write_reg(REG_END_BYTE, 8'hFF);
               end
               default: begin
                  write_reg(REG_START_BYTE, 8'($urandom_range(0, 255)));
                  write_reg(REG_END_BYTE, 8'($urandom_range(0, 255)));
               end
            endcase
         end
         phase_end = words_sent + WORDS_PER_PHASE;
         while (words_sent < phase_end) random_packet(1'b1);
         random_packet(1'b0);
      end

      req_valid <= 1'b0;
      wait (outstanding == 0);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // chunk side: random stalls, calm stretches, and two long hold-offs
   // while words keep coming so the queue fills and req_stall rises
   initial begin : rsp_side
      int hold_idx;
      int gap;
      rsp_stall = 1'b0;
      hold_idx = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_idx < 2 && words_sent >= backlog_at[hold_idx]) begin
            rsp_stall <= 1'b1;
            repeat (BACKLOG_CYCLES) @(negedge clock);
            hold_idx++;
         end else begin
            gap = idle_span(1'b0);
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(negedge clock);
            end
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 9) == 0)
               repeat ($urandom_range(20, 60)) @(negedge clock);
            else
               repeat ($urandom_range(1, 4)) @(negedge clock);
         end
      end
   end

   initial begin : watchdog
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/cpf_pkg.sv
rtl/cpf_frame.sv
rtl/cpf_queue.sv
rtl/command_packet_framer.sv
tb/cpf_chunk_checker.sv
tb/tb_command_packet_framer.sv
